// ===== rtl/fstm_pkg.sv =====
package fstm_pkg;

    // Fixed field widths
    localparam int ADDR_W       = 24;
    localparam int TADDR_W      = 13;
    localparam int UV_W         = 32;
    localparam int UV_FRAC      = 16;
    localparam int TILE_LOG     = 6;
    localparam int TILE_AW      = 2 * TILE_LOG;
    localparam int TILE_DEPTH   = 1 << TILE_AW;
    localparam int COUNT_W      = 9;
    localparam int LIGHT_IN_W   = 5;
    localparam int LIGHT_W_MAX  = 6;

    // Defaults for the top-level parameters
    localparam int SCREEN_WIDTH_DEF = 320;
    localparam int LIGHT_LEVELS_DEF = 32;

    // Configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [1:0] REG_FRAME_BASE = 2'd0;
    localparam logic [1:0] REG_WINDOW_X   = 2'd1;
    localparam logic [1:0] REG_WINDOW_Y   = 2'd2;
    localparam logic [1:0] REG_LOW_DETAIL = 2'd3;

    typedef enum logic [1:0] {
        ACT_LOAD_TEXEL = 2'd0,
        ACT_LOAD_SHADE = 2'd1,
        ACT_START      = 2'd2,
        ACT_DRAW       = 2'd3
    } action_t;

    typedef struct packed {
        logic [ADDR_W-1:0] frame_base;
        logic [8:0]        window_x;
        logic [7:0]        window_y;
        logic              low_detail;
    } cfg_t;

    // One draw in flight between the texel read and the colour map read
    typedef struct packed {
        logic                   valid;
        logic [LIGHT_W_MAX-1:0] light;
        logic [ADDR_W-1:0]      address;
        logic                   last;
        logic                   pair;
    } draw_meta_t;

    typedef struct packed {
        logic               en;
        logic [TADDR_W-1:0] addr;
        logic [7:0]         data;
    } shade_wr_t;

endpackage

// ===== rtl/fstm_ifs.sv =====
interface fstm_req_if
    import fstm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    action_t                  action;
    logic [TADDR_W-1:0]       table_addr;
    logic [7:0]               table_data;
    logic signed [UV_W-1:0]   u_start;
    logic signed [UV_W-1:0]   v_start;
    logic signed [UV_W-1:0]   u_step;
    logic signed [UV_W-1:0]   v_step;
    logic [7:0]               row;
    logic [8:0]               start_column;
    logic [COUNT_W-1:0]       span_length;
    logic [LIGHT_IN_W-1:0]    light_level;

    modport source (
        output valid, action, table_addr, table_data, u_start, v_start,
               u_step, v_step, row, start_column, span_length, light_level,
        input  ready
    );
    modport sink (
        input  valid, action, table_addr, table_data, u_start, v_start,
               u_step, v_step, row, start_column, span_length, light_level,
        output ready
    );
endinterface

interface fstm_rsp_if
    import fstm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [7:0]        pixel;
    logic [ADDR_W-1:0] address;
    logic              last;

    modport source (
        output valid, pixel, address, last,
        input  ready
    );
    modport sink (
        input  valid, pixel, address, last,
        output ready
    );
endinterface

// ===== rtl/fstm_cfg_regs.sv =====
module fstm_cfg_regs
    import fstm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_FRAME_BASE: cfg_next.frame_base = pwdata[ADDR_W-1:0];
                REG_WINDOW_X:   cfg_next.window_x   = pwdata[8:0];
                REG_WINDOW_Y:   cfg_next.window_y   = pwdata[7:0];
                REG_LOW_DETAIL: cfg_next.low_detail = pwdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_FRAME_BASE: prdata = CFG_DW'(cfg_reg.frame_base);
            REG_WINDOW_X:   prdata = CFG_DW'(cfg_reg.window_x);
            REG_WINDOW_Y:   prdata = CFG_DW'(cfg_reg.window_y);
            REG_LOW_DETAIL: prdata = CFG_DW'(cfg_reg.low_detail);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/fstm_span_front.sv =====
module fstm_span_front
    import fstm_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
    parameter int LIGHT_LEVELS = LIGHT_LEVELS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    fstm_req_if.sink      req,
    input  cfg_t          cfg,
    input  logic          s2_free,
    output draw_meta_t    s1_meta,
    output logic [7:0]    s1_texel,
    output logic          adv1,
    output shade_wr_t     shade_wr
);

    logic [7:0]         texel_mem [TILE_DEPTH];
    logic [7:0]         texel_reg;

    logic [UV_W-1:0]    u_pos_reg,  u_pos_next;
    logic [UV_W-1:0]    v_pos_reg,  v_pos_next;
    logic [UV_W-1:0]    u_inc_reg,  u_inc_next;
    logic [UV_W-1:0]    v_inc_reg,  v_inc_next;
    logic [COUNT_W-1:0] left_reg,   left_next;
    logic [ADDR_W-1:0]  waddr_reg,  waddr_next;
    logic [LIGHT_W_MAX-1:0] light_reg, light_next;
    draw_meta_t         meta_reg,   meta_next;

    logic               accept;
    logic               draw_go;
    logic [TILE_AW-1:0] spot;
    logic [8:0]         row_sum;
    logic [9:0]         col;
    logic [ADDR_W-1:0]  start_addr;
    logic [LIGHT_W_MAX-1:0] light_sat;

    assign adv1      = meta_reg.valid && s2_free;
    assign req.ready = !meta_reg.valid || s2_free;
    assign accept    = req.valid && req.ready;
    assign draw_go   = accept && (req.action == ACT_DRAW) && (left_reg != '0);

    assign s1_meta  = meta_reg;
    assign s1_texel = texel_reg;

    assign shade_wr.en   = accept && (req.action == ACT_LOAD_SHADE);
    assign shade_wr.addr = req.table_addr;
    assign shade_wr.data = req.table_data;

    // Tile row from V, tile column from U
    assign spot = {v_pos_reg[UV_FRAC+TILE_LOG-1:UV_FRAC], u_pos_reg[UV_FRAC+TILE_LOG-1:UV_FRAC]};

    assign row_sum    = {1'b0, req.row} + {1'b0, cfg.window_y};
    assign col        = cfg.low_detail ? {req.start_column, 1'b0} : {1'b0, req.start_column};
    assign start_addr = cfg.frame_base + ADDR_W'(int'(row_sum) * SCREEN_WIDTH)
                        + ADDR_W'(cfg.window_x) + ADDR_W'(col);
    assign light_sat  = (int'(req.light_level) >= LIGHT_LEVELS)
                        ? LIGHT_W_MAX'(LIGHT_LEVELS - 1) : LIGHT_W_MAX'(req.light_level);

    always_comb
    begin
        u_pos_next = u_pos_reg;
        v_pos_next = v_pos_reg;
        u_inc_next = u_inc_reg;
        v_inc_next = v_inc_reg;
        left_next  = left_reg;
        waddr_next = waddr_reg;
        light_next = light_reg;
        meta_next  = meta_reg;

        if (adv1)
        begin
            meta_next.valid = 1'b0;
        end

        if (accept && (req.action == ACT_START))
        begin
            u_pos_next = req.u_start;
            v_pos_next = req.v_start;
            u_inc_next = req.u_step;
            v_inc_next = req.v_step;
            left_next  = req.span_length;
            waddr_next = start_addr;
            light_next = light_sat;
        end

        if (draw_go)
        begin
            meta_next.valid   = 1'b1;
            meta_next.light   = light_reg;
            meta_next.address = waddr_reg;
            meta_next.last    = (left_reg == COUNT_W'(1));
            meta_next.pair    = cfg.low_detail;
            waddr_next = waddr_reg + (cfg.low_detail ? ADDR_W'(2) : ADDR_W'(1));
            u_pos_next = u_pos_reg + u_inc_reg;
            v_pos_next = v_pos_reg + v_inc_reg;
            left_next  = left_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_pos_reg <= '0;
            v_pos_reg <= '0;
            u_inc_reg <= '0;
            v_inc_reg <= '0;
            left_reg  <= '0;
            waddr_reg <= '0;
            light_reg <= '0;
            meta_reg  <= '0;
        end
        else
        begin
            u_pos_reg <= u_pos_next;
            v_pos_reg <= v_pos_next;
            u_inc_reg <= u_inc_next;
            v_inc_reg <= v_inc_next;
            left_reg  <= left_next;
            waddr_reg <= waddr_next;
            light_reg <= light_next;
            meta_reg  <= meta_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (req.action == ACT_LOAD_TEXEL))
        begin
            texel_mem[req.table_addr[TILE_AW-1:0]] <= req.table_data;
        end
        if (draw_go)
        begin
            texel_reg <= texel_mem[spot];
        end
    end

endmodule

// ===== rtl/fstm_shade_out.sv =====
module fstm_shade_out
    import fstm_pkg::*;
#(
    parameter int LIGHT_LEVELS = LIGHT_LEVELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  draw_meta_t  s1_meta,
    input  logic [7:0]  s1_texel,
    input  logic        adv1,
    input  shade_wr_t   shade_wr,
    output logic        s2_free,
    fstm_rsp_if.source  rsp
);

    localparam int SHADE_DEPTH = LIGHT_LEVELS * 256;
    localparam int SHADE_AW    = $clog2(SHADE_DEPTH);

    logic [7:0]          shade_mem [SHADE_DEPTH];
    logic [7:0]          shade_reg;

    logic                valid_reg,  valid_next;
    logic                phase_reg,  phase_next;
    logic [ADDR_W-1:0]   addr_reg,   addr_next;
    logic                last_reg,   last_next;
    logic                pair_reg,   pair_next;

    logic                out_fire;
    logic                final_beat;
    logic [SHADE_AW-1:0] sidx;

    assign sidx       = SHADE_AW'({s1_meta.light, s1_texel});
    assign out_fire   = rsp.valid && rsp.ready;
    assign final_beat = !pair_reg || phase_reg;
    assign s2_free    = !valid_reg || (out_fire && final_beat);

    assign rsp.valid   = valid_reg;
    assign rsp.pixel   = shade_reg;
    assign rsp.address = addr_reg + ADDR_W'(phase_reg);
    assign rsp.last    = last_reg && final_beat;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        addr_next  = addr_reg;
        last_next  = last_reg;
        pair_next  = pair_reg;
        if (adv1)
        begin
            valid_next = 1'b1;
            phase_next = 1'b0;
            addr_next  = s1_meta.address;
            last_next  = s1_meta.last;
            pair_next  = s1_meta.pair;
        end
        else if (out_fire && final_beat)
        begin
            valid_next = 1'b0;
            phase_next = 1'b0;
        end
        else if (out_fire)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
            addr_reg  <= '0;
            last_reg  <= 1'b0;
            pair_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            last_reg  <= last_next;
            pair_reg  <= pair_next;
        end
    end

    // Read before write on the same edge keeps earlier draws on the old entry
    always_ff @(posedge clk)
    begin
        if (shade_wr.en && (int'(shade_wr.addr) < SHADE_DEPTH))
        begin
            shade_mem[SHADE_AW'(shade_wr.addr)] <= shade_wr.data;
        end
        if (adv1)
        begin
            shade_reg <= shade_mem[sidx];
        end
    end

endmodule

// ===== rtl/flat_span_texel_mapper.sv =====
// Affine span texture mapper over one 64x64 texel tile.
//
// req channel: one request per cycle when ready. Load texel and load colour map
// requests fill the tile memory and the light-level colour maps; a start request
// latches the 16.16 U/V position and steps, the light level and the span length,
// and forms the first framebuffer byte address. Each draw request emits one
// remapped texel (two in low-detail mode, at adjacent bytes) and steps U/V.
// Draws past the end of the span are taken and dropped.
// rsp channel: pixel, framebuffer address and last on the final byte of the span.
// A draw reads the tile memory as it is accepted and the colour map as it moves
// into the output stage, which then offers it on rsp.
// Throughput: one draw per cycle while rsp takes every byte, set by the single read port of each memory;
// in low-detail mode a draw holds the output for two bytes, set by the one-byte rsp port.
// A result stalled on rsp holds in the output stage while one more draw waits
// behind it after its tile read; ready then drops until the output stage is free.
// Reset clears the span state (no span active) and the registers; both memories
// hold nothing defined until loaded. Registers sit on an APB port; the user must write
// them only while the block is idle: the block itself does not enforce this.
module flat_span_texel_mapper
    import fstm_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
    parameter int LIGHT_LEVELS = LIGHT_LEVELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    fstm_req_if.sink          req,
    fstm_rsp_if.source        rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg;
    draw_meta_t s1_meta;
    logic [7:0] s1_texel;
    logic       adv1;
    logic       s2_free;
    shade_wr_t  shade_wr;

    // Register file: frame base, window offsets, low-detail mode
    fstm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Span state, tile memory and tile read stage
    fstm_span_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .LIGHT_LEVELS (LIGHT_LEVELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg      (cfg),
        .s2_free  (s2_free),
        .s1_meta  (s1_meta),
        .s1_texel (s1_texel),
        .adv1     (adv1),
        .shade_wr (shade_wr)
    );

    // Colour map memory and output stage; splits low-detail draws into byte pairs
    fstm_shade_out #(
        .LIGHT_LEVELS (LIGHT_LEVELS)
    ) u_shade (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_meta  (s1_meta),
        .s1_texel (s1_texel),
        .adv1     (adv1),
        .shade_wr (shade_wr),
        .s2_free  (s2_free),
        .rsp      (rsp)
    );

endmodule

// ===== tb/flat_span_texel_mapper_test.sv =====
`timescale 1ns / 100ps

module flat_span_texel_mapper_test;
    import fstm_pkg::*;

    // Block geometry as built here (top-level parameters left at their defaults)
    localparam int SCREEN_W    = SCREEN_WIDTH_DEF;
    localparam int LIGHTS      = LIGHT_LEVELS_DEF;
    localparam int SHADE_DEPTH = LIGHTS * 256;

    // Cycles to let pass after the last expected pixel, so a stray write still left
    // in the two-stage read pipeline is seen.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int LONG_HOLD_OFF = 200;
    localparam longint TIMEOUT_NS = 4000000;

    // One request as the sender sees it; every field is driven on every request
    typedef struct {
        action_t     action;
        logic [12:0] table_addr;
        logic [7:0]  table_data;
        logic [31:0] u_start;
        logic [31:0] v_start;
        logic [31:0] u_step;
        logic [31:0] v_step;
        logic [7:0]  row;
        logic [8:0]  start_column;
        logic [8:0]  span_length;
        logic [4:0]  light_level;
    } span_request_t;

    // One framebuffer byte write as it leaves the block
    typedef struct {
        logic [7:0]        pixel;
        logic [ADDR_W-1:0] address;
        logic              last;
    } pixel_write_t;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    fstm_req_if req_bus ();
    fstm_rsp_if rsp_bus ();

    flat_span_texel_mapper dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_bus),
        .rsp     (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted block state: tile and colour maps, span registers and a
    // mirror of the configuration registers.
    // ------------------------------------------------------------------
    logic [7:0]        tile_mem [TILE_DEPTH];
    logic [7:0]        shade_mem [SHADE_DEPTH];
    bit                tex_written [TILE_DEPTH];
    bit                shade_written [SHADE_DEPTH];
    logic [31:0]       u_pos;
    logic [31:0]       v_pos;
    logic [31:0]       u_inc;
    logic [31:0]       v_inc;
    logic [8:0]        pixels_left;
    logic [ADDR_W-1:0] write_addr;
    logic [5:0]        span_light;
    cfg_t              cfg_mirror;

    // Framebuffer writes predicted but not yet seen on rsp, oldest first
    pixel_write_t pending_pixels [$];

    int unsigned error_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;
    int unsigned hold_off_left = 0;
    int unsigned requests_sent = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Advance the predicted state by one accepted request and queue the
    // framebuffer writes it causes.
    task automatic predict_span_pixels(input span_request_t r);
        logic [31:0]  first_addr;
        logic [31:0]  col;
        logic [11:0]  spot;
        logic [31:0]  shade_idx;
        logic [7:0]   pix;
        logic         last_byte;
        int unsigned  light;
        pixel_write_t w;

        case (r.action)
            ACT_LOAD_TEXEL:
            begin
                // bit 12 of the address is dropped: the tile wraps at 4096
                tile_mem[r.table_addr[TILE_AW-1:0]]    = r.table_data;
                tex_written[r.table_addr[TILE_AW-1:0]] = 1'b1;
            end
            ACT_LOAD_SHADE:
            begin
                if (r.table_addr < SHADE_DEPTH)
                begin
                    shade_mem[r.table_addr]     = r.table_data;
                    shade_written[r.table_addr] = 1'b1;
                end
            end
            ACT_START:
            begin
                light = r.light_level;
                if (light >= LIGHTS)
                    light = LIGHTS - 1;
                u_pos       = r.u_start;
                v_pos       = r.v_start;
                u_inc       = r.u_step;
                v_inc       = r.v_step;
                span_light  = 6'(light);
                pixels_left = r.span_length;
                // low detail at the start request doubles the first column
                col = cfg_mirror.low_detail ? 32'(r.start_column) << 1 : 32'(r.start_column);
                first_addr = 32'(cfg_mirror.frame_base)
                           + (32'(r.row) + 32'(cfg_mirror.window_y)) * SCREEN_W
                           + 32'(cfg_mirror.window_x) + col;
                write_addr = first_addr[ADDR_W-1:0];
            end
            ACT_DRAW:
            begin
                // past the span end: nothing comes out and nothing moves
                if (pixels_left != 0)
                begin
                    // row from V integer bits, column from U integer bits, both mod 64
                    spot      = {v_pos[UV_FRAC+5:UV_FRAC], u_pos[UV_FRAC+5:UV_FRAC]};
                    shade_idx = 32'(span_light) * 256 + 32'(tile_mem[spot]);
                    pix       = (shade_idx < SHADE_DEPTH) ? shade_mem[shade_idx] : 8'd0;
                    last_byte = (pixels_left == 9'd1);
                    // low detail as it is now decides doubling and the step
                    if (cfg_mirror.low_detail)
                    begin
                        w.pixel   = pix;
                        w.address = write_addr;
                        w.last    = 1'b0;
                        pending_pixels.push_back(w);
                        w.address = write_addr + 1'b1;
                        w.last    = last_byte;
                        pending_pixels.push_back(w);
                        write_addr = write_addr + 2'd2;
                    end
                    else
                    begin
                        w.pixel   = pix;
                        w.address = write_addr;
                        w.last    = last_byte;
                        pending_pixels.push_back(w);
                        write_addr = write_addr + 1'b1;
                    end
                    u_pos       = u_pos + u_inc;
                    v_pos       = v_pos + v_inc;
                    pixels_left = pixels_left - 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request sender. Hold valid across back-to-back requests; drop it only
    // for an idle gap. Call at a rising edge; returns at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_request(input span_request_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_bus.valid        <= 1'b1;
        req_bus.action       <= r.action;
        req_bus.table_addr   <= r.table_addr;
        req_bus.table_data   <= r.table_data;
        req_bus.u_start      <= r.u_start;
        req_bus.v_start      <= r.v_start;
        req_bus.u_step       <= r.u_step;
        req_bus.v_step       <= r.v_step;
        req_bus.row          <= r.row;
        req_bus.start_column <= r.start_column;
        req_bus.span_length  <= r.span_length;
        req_bus.light_level  <= r.light_level;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        requests_sent++;
        predict_span_pixels(r);
    endtask

    // Fill every field with noise, then fix the action
    function automatic span_request_t random_request(input action_t a);
        span_request_t r;
        r.action       = a;
        r.table_addr   = 13'($urandom);
        r.table_data   = 8'($urandom);
        r.u_start      = $urandom;
        r.v_start      = $urandom;
        r.u_step       = $urandom;
        r.v_step       = $urandom;
        r.row          = 8'($urandom);
        r.start_column = 9'($urandom_range(0, 319));
        r.span_length  = 9'($urandom_range(1, 320));
        r.light_level  = 5'($urandom);
        return r;
    endfunction

    // Load the texel and the colour map entry the next draw reads when they
    // hold nothing defined yet, then send the draw.
    task automatic send_draw();
        span_request_t r;
        logic [11:0]   spot;
        logic [31:0]   shade_idx;
        if (pixels_left != 0)
        begin
            spot = {v_pos[UV_FRAC+5:UV_FRAC], u_pos[UV_FRAC+5:UV_FRAC]};
            if (!tex_written[spot])
            begin
                r = random_request(ACT_LOAD_TEXEL);
                r.table_addr = 13'(spot);
                send_request(r);
            end
            shade_idx = 32'(span_light) * 256 + 32'(tile_mem[spot]);
            if (!shade_written[shade_idx[12:0]])
            begin
                r = random_request(ACT_LOAD_SHADE);
                r.table_addr = shade_idx[12:0];
                send_request(r);
            end
        end
        send_request(random_request(ACT_DRAW));
    endtask

    // Stop offering requests and wait for every predicted pixel, then let the
    // pipeline settle so a stray write would still be seen.
    task automatic drain_pixels();
        int unsigned waited;
        waited = 0;
        req_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_FRAME_BASE: cfg_mirror.frame_base = value[ADDR_W-1:0];
            REG_WINDOW_X:   cfg_mirror.window_x   = value[8:0];
            REG_WINDOW_Y:   cfg_mirror.window_y   = value[7:0];
            REG_LOW_DETAIL: cfg_mirror.low_detail = value[0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Change idling odds away from the rising edge so the receiver process
    // never races the update.
    task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
        @(negedge clk);
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_extreme(input logic [31:0] lo, input logic [31:0] hi);
        case ($urandom_range(2))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    task automatic pick_random_settings();
        write_reg(REG_FRAME_BASE, pick_extreme(0, 32'hFF_FFFF));
        write_reg(REG_WINDOW_X,   pick_extreme(0, 319));
        write_reg(REG_WINDOW_Y,   pick_extreme(0, 255));
        write_reg(REG_LOW_DETAIL, $urandom_range(1));
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a long hold-off when one is pending
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else if (hold_off_left != 0)
        begin
            rsp_bus.ready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end
        else
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Compare every byte that leaves the block with the oldest prediction
    always @(posedge clk)
    begin
        pixel_write_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch($sformatf("unexpected write pixel=%h address=%h last=%b",
                                          rsp_bus.pixel, rsp_bus.address, rsp_bus.last));
            else
            begin
                want = pending_pixels.pop_front();
                if (rsp_bus.pixel !== want.pixel)
                    report_mismatch($sformatf("pixel %h, want %h at address %h",
                                              rsp_bus.pixel, want.pixel, want.address));
                if (rsp_bus.address !== want.address)
                    report_mismatch($sformatf("address %h, want %h",
                                              rsp_bus.address, want.address));
                if (rsp_bus.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b at address %h",
                                              rsp_bus.last, want.last, want.address));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at reset values; field extremes and the odd corners
    task automatic test_directed_spans();
        span_request_t r;
        int unsigned   i;

        // draw with no span active
        send_draw();

        // zero-length span leaves nothing to draw
        r = random_request(ACT_START);
        r.span_length = 9'd0;
        send_request(r);
        send_draw();

        // texel load with the high address bit set lands on texel 5
        r = random_request(ACT_LOAD_TEXEL);
        r.table_addr = 13'h1005;
        r.table_data = 8'hFF;
        send_request(r);

        // colour map extremes
        r = random_request(ACT_LOAD_SHADE);
        r.table_addr = 13'h1FFF;
        r.table_data = 8'hFF;
        send_request(r);
        r.table_addr = 13'h0000;
        r.table_data = 8'h00;
        send_request(r);

        // every field at an extreme, one pixel, then a draw past the end
        r = random_request(ACT_START);
        r.u_start      = 32'h8000_0000;
        r.v_start      = 32'h7FFF_FFFF;
        r.u_step       = 32'h7FFF_FFFF;
        r.v_step       = 32'h8000_0000;
        r.row          = 8'd255;
        r.start_column = 9'd319;
        r.span_length  = 9'd1;
        r.light_level  = 5'd31;
        send_request(r);
        send_draw();
        send_draw();

        // light 0 at texel 5 with zero steps, one extra draw past the end
        r = random_request(ACT_START);
        r.u_start      = 32'h0005_0000;
        r.v_start      = 32'h0000_0000;
        r.u_step       = 32'h0000_0000;
        r.v_step       = 32'h0000_0000;
        r.row          = 8'd0;
        r.start_column = 9'd0;
        r.span_length  = 9'd3;
        r.light_level  = 5'd0;
        send_request(r);
        for (i = 0; i < 4; i++)
            send_draw();
        drain_pixels();
    endtask

    // Registers at their top values: the address wraps and low detail doubles
    task automatic test_register_extremes();
        span_request_t r;
        int unsigned   i;
        write_reg(REG_FRAME_BASE, 32'hFF_FFFF);
        write_reg(REG_WINDOW_X,   319);
        write_reg(REG_WINDOW_Y,   255);
        write_reg(REG_LOW_DETAIL, 1);
        r = random_request(ACT_START);
        r.row          = 8'd255;
        r.start_column = 9'd319;
        r.span_length  = 9'd3;
        send_request(r);
        for (i = 0; i < 3; i++)
            send_draw();
        drain_pixels();
    endtask

    // Low detail flips between draws of one span
    task automatic test_low_detail_midspan();
        span_request_t r;
        int unsigned   i;
        write_reg(REG_LOW_DETAIL, 0);
        r = random_request(ACT_START);
        r.span_length = 9'd5;
        send_request(r);
        for (i = 0; i < 2; i++)
            send_draw();
        drain_pixels();
        write_reg(REG_LOW_DETAIL, 1);
        for (i = 0; i < 2; i++)
            send_draw();
        drain_pixels();
        write_reg(REG_LOW_DETAIL, 0);
        for (i = 0; i < 2; i++)
            send_draw();
        drain_pixels();
    endtask

    // Hold the receiver off while draws keep coming: the block must fill
    // and stall its input, then drain without loss.
    task automatic test_output_backpressure();
        span_request_t r;
        int unsigned   i;
        set_idling(0, 0);
        r = random_request(ACT_START);
        r.span_length = 9'd60;
        send_request(r);
        @(negedge clk);
        hold_off_left = LONG_HOLD_OFF;
        @(posedge clk);
        for (i = 0; i < 60; i++)
            send_draw();
        // pause the sender until every pixel is out
        drain_pixels();
    endtask

    // Mostly whole spans with random content; loads, stray draws and cut-off
    // spans as noise. Every request counts, loads made for a draw included.
    task automatic run_random_traffic(input int unsigned n_items);
        span_request_t r;
        int unsigned   first;
        int unsigned   pick;
        int unsigned   n_draws;
        int unsigned   i;
        first = requests_sent;
        while (requests_sent - first < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_request(random_request(pick[0] ? ACT_LOAD_TEXEL : ACT_LOAD_SHADE));
            else if (pick < 12)
                send_draw();
            else
            begin
                r = random_request(ACT_START);
                // short spans mostly, now and then any length the field holds
                if ($urandom_range(19) == 0)
                    r.span_length = 9'($urandom);
                else
                    r.span_length = 9'($urandom_range(1, 12));
                if ($urandom_range(1) == 0)
                begin
                    r.u_step = 32'($urandom_range(0, 32'h3FFFF)) - 32'h1FFFF;
                    r.v_step = 32'($urandom_range(0, 32'h3FFFF)) - 32'h1FFFF;
                end
                send_request(r);
                // cut a span short now and then, else run to its end or slightly past it
                if ($urandom_range(9) == 0)
                    n_draws = $urandom_range(r.span_length);
                else
                    n_draws = r.span_length + $urandom_range(2);
                for (i = 0; i < n_draws; i++)
                    send_draw();
            end
        end
        drain_pixels();
    endtask

    task automatic test_random_phases();
        pick_random_settings();
        set_idling(0, 0);
        run_random_traffic(100);
        pick_random_settings();
        set_idling(63, 0);
        run_random_traffic(100);
        pick_random_settings();
        set_idling(0, 63);
        run_random_traffic(100);
        pick_random_settings();
        set_idling(38, 38);
        run_random_traffic(100);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        req_bus.valid        <= 1'b0;
        req_bus.action       <= ACT_LOAD_TEXEL;
        req_bus.table_addr   <= '0;
        req_bus.table_data   <= '0;
        req_bus.u_start      <= '0;
        req_bus.v_start      <= '0;
        req_bus.u_step       <= '0;
        req_bus.v_step       <= '0;
        req_bus.row          <= '0;
        req_bus.start_column <= '0;
        req_bus.span_length  <= '0;
        req_bus.light_level  <= '0;

        // reset values of the predicted state
        u_pos       = '0;
        v_pos       = '0;
        u_inc       = '0;
        v_inc       = '0;
        pixels_left = '0;
        write_addr  = '0;
        span_light  = '0;
        cfg_mirror  = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_spans();
        test_register_extremes();
        test_low_detail_midspan();
        test_output_backpressure();
        test_random_phases();

        set_idling(0, 0);
        drain_pixels();
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d pixel writes never arrived", pending_pixels.size()));

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
